>>> hdl/ffsa_pkg.sv
`default_nettype none

package ffsa_pkg;

    localparam logic OP_ALLOCATE = 1'b0;
    localparam logic OP_FREE     = 1'b1;

    localparam logic [1:0] STATUS_ALLOCATED = 2'd0;
    localparam logic [1:0] STATUS_NONE_FREE = 2'd1;
    localparam logic [1:0] STATUS_FREED     = 2'd2;
    localparam logic [1:0] STATUS_INVALID   = 2'd3;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_USE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS_IN_USE = 1'd1;

    localparam logic [CFG_DATA_W-1:0] ROWS_RESET = 5'd16;
    localparam logic [CFG_DATA_W-1:0] COLS_RESET = 5'd16;

    // counts wide enough for up to 511 rows and 127 columns
    localparam int ROW_CNT_W = 9;
    localparam int COL_CNT_W = 7;

    typedef struct packed {
        logic       operation;
        logic [3:0] seat_row;
        logic [3:0] seat_col;
    } t_in_item;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] got_row;
        logic [3:0] got_col;
    } t_out_item;

    typedef struct packed {
        logic load;
        logic scan_next;
        logic commit_alloc;
        logic commit_free;
        logic emit_none;
    } t_dp_cmd;

    typedef struct packed {
        logic grid_empty;
        logic found;
        logic last_row;
    } t_dp_status;

endpackage

`default_nettype wire

>>> hdl/ffsa_ctrl.sv
`default_nettype none

module ffsa_ctrl
    import ffsa_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_start,
    input  wire logic       i_operation,
    input  wire t_dp_status i_status,
    output logic            o_busy,
    output t_dp_cmd         o_cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ALLOC = 2'd1;
    localparam logic [1:0] ST_FREE  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    if (i_operation == OP_FREE) begin
                        n_state = ST_FREE;
                    end else if (i_status.grid_empty) begin
                        o_cmd.emit_none = 1'b1;
                    end else begin
                        n_state = ST_ALLOC;
                    end
                end
            end
            ST_ALLOC: begin
                if (i_status.found) begin
                    o_cmd.commit_alloc = 1'b1;
                    n_state            = ST_IDLE;
                end else if (i_status.last_row) begin
                    o_cmd.emit_none = 1'b1;
                    n_state         = ST_IDLE;
                end else begin
                    o_cmd.scan_next = 1'b1;
                end
            end
            ST_FREE: begin
                o_cmd.commit_free = 1'b1;
                n_state           = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

`default_nettype wire

>>> hdl/ffsa_datapath.sv
`default_nettype none

module ffsa_datapath
    import ffsa_pkg::*;
#(
    parameter int MAX_ROWS = 16,
    parameter int MAX_COLS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_in_item              i_in,
    input  wire logic [CFG_DATA_W-1:0] i_rows,
    input  wire logic [CFG_DATA_W-1:0] i_cols,
    input  wire t_dp_cmd               i_cmd,
    output t_dp_status                 o_status,
    output logic                       o_result_valid,
    output t_out_item                  o_result
);

    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

    logic [MAX_COLS-1:0] mem [MAX_ROWS];
    logic [MAX_ROWS-1:0] r_row_vld;
    logic [MAX_COLS-1:0] r_rd_data;
    logic                r_rd_vld;
    logic [RW-1:0]       r_chk_row;
    logic [3:0]          r_seat_row;
    logic [3:0]          r_seat_col;
    logic                r_result_valid;
    t_out_item           r_result;

    logic [ROW_CNT_W-1:0] nr;
    logic [COL_CNT_W-1:0] nc;
    logic [MAX_COLS-1:0]  rd_word;
    logic [MAX_COLS-1:0]  col_mask;
    logic [MAX_COLS-1:0]  taken;
    logic                 found;
    logic [CW-1:0]        first;
    logic [CW-1:0]        seat_col_idx;
    logic                 free_hit;
    logic                 rd_en;
    logic [RW-1:0]        rd_addr;
    logic                 wr_en;
    logic [MAX_COLS-1:0]  wr_word;

    assign nr = (ROW_CNT_W'(i_rows) > ROW_CNT_W'(MAX_ROWS)) ? ROW_CNT_W'(MAX_ROWS)
                                                             : ROW_CNT_W'(i_rows);
    assign nc = (COL_CNT_W'(i_cols) > COL_CNT_W'(MAX_COLS)) ? COL_CNT_W'(MAX_COLS)
                                                             : COL_CNT_W'(i_cols);

    assign rd_word = r_rd_vld ? r_rd_data : '0;

    always_comb begin
        for (int j = 0; j < MAX_COLS; j++) begin
            col_mask[j] = (COL_CNT_W'(j) < nc);
        end
    end

    assign taken = rd_word | ~col_mask;

    // first free column, lowest index wins
    always_comb begin
        found = 1'b0;
        first = '0;
        for (int j = MAX_COLS - 1; j >= 0; j--) begin
            if (!taken[j]) begin
                found = 1'b1;
                first = CW'(j);
            end
        end
    end

    assign seat_col_idx = CW'(r_seat_col);
    assign free_hit     = (ROW_CNT_W'(r_seat_row) < nr) && (COL_CNT_W'(r_seat_col) < nc)
                          && rd_word[seat_col_idx];

    assign o_status.grid_empty = (nr == '0) || (nc == '0);
    assign o_status.found      = found;
    assign o_status.last_row   = ((ROW_CNT_W'(r_chk_row) + ROW_CNT_W'(1)) == nr);

    assign rd_en   = i_cmd.load | i_cmd.scan_next;
    assign rd_addr = i_cmd.scan_next           ? r_chk_row + RW'(1) :
                     (i_in.operation == OP_FREE) ? RW'(i_in.seat_row) : '0;

    assign wr_en   = i_cmd.commit_alloc | (i_cmd.commit_free & free_hit);
    assign wr_word = i_cmd.commit_alloc ? (rd_word | (MAX_COLS'(1) << first))
                                        : (rd_word & ~(MAX_COLS'(1) << seat_col_idx));

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_chk_row] <= wr_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            if (wr_en) begin
                r_row_vld[r_chk_row] <= 1'b1;
            end
            if (rd_en) begin
                r_rd_vld <= r_row_vld[rd_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_chk_row <= rd_addr;
        end
        if (i_cmd.load) begin
            r_seat_row <= i_in.seat_row;
            r_seat_col <= i_in.seat_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_result_valid <= 1'b0;
        end else begin
            r_result_valid <= i_cmd.commit_alloc | i_cmd.commit_free | i_cmd.emit_none;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit_alloc) begin
            r_result.status  <= STATUS_ALLOCATED;
            r_result.got_row <= 4'(r_chk_row);
            r_result.got_col <= 4'(first);
        end else if (i_cmd.commit_free) begin
            r_result.status  <= free_hit ? STATUS_FREED : STATUS_INVALID;
            r_result.got_row <= '0;
            r_result.got_col <= '0;
        end else if (i_cmd.emit_none) begin
            r_result.status  <= STATUS_NONE_FREE;
            r_result.got_row <= '0;
            r_result.got_col <= '0;
        end
    end

    assign o_result_valid = r_result_valid;
    assign o_result       = r_result;

endmodule

`default_nettype wire

>>> hdl/first_free_seat_allocator.sv
`default_nettype none

// First-fit seat allocator over an occupancy bitmap of MAX_ROWS x MAX_COLS seats.
// Input: an item is taken at a clock edge with i_start high and o_busy low.
//   operation allocate finds the first free seat in row-major order inside the
//   rows_in_use x cols_in_use grid; operation free clears the named seat.
// Output: o_result_valid pulses for one cycle with o_result; the receiver cannot
//   stall, so the result must be captured in that cycle.
// Sequence: free reads the named row, then commits in the FREE state. Allocate reads one bitmap
//   row per cycle from the row memory and runs a find-first-zero over it, scanning
//   at most the active rows; an empty grid answers from idle, its result registered
//   in the cycle after acceptance. o_busy is high while an item is in
//   work; a new item may be started in the cycle its predecessor's result shows.
// Configuration: i_cfg_index 0 is rows_in_use, 1 is cols_in_use, both reset to 16
//   and clamped to MAX_ROWS / MAX_COLS. o_cfg_ready is always high; write only
//   while o_busy is low.
// Reset: all seats free (per-row valid bits cleared at once), no result pending.
module first_free_seat_allocator
    import ffsa_pkg::*;
#(
    parameter int MAX_ROWS = 16,
    parameter int MAX_COLS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    output logic                       o_busy,
    input  wire t_in_item              i_in,
    output logic                       o_result_valid,
    output t_out_item                  o_result,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [CFG_DATA_W-1:0] r_rows;
    logic [CFG_DATA_W-1:0] r_cols;
    t_dp_cmd               cmd;
    t_dp_status            status;
    logic                  busy;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= ROWS_RESET;
            r_cols <= COLS_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_ROWS_IN_USE: r_rows <= i_cfg_data;
                REG_COLS_IN_USE: r_cols <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    ffsa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_operation (i_in.operation),
        .i_status    (status),
        .o_busy      (busy),
        .o_cmd       (cmd)
    );

    ffsa_datapath #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in           (i_in),
        .i_rows         (r_rows),
        .i_cols         (r_cols),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

    assign o_busy = busy;

endmodule

`default_nettype wire
